FILE: sv/tes_pkg.sv
`default_nettype none
package tes_pkg;

   // byte-order mark codes
   typedef enum logic [1:0] {
      MARK_NONE = 2'd0,
      MARK_UTF8 = 2'd1,
      MARK_LE   = 2'd2,
      MARK_BE   = 2'd3
   } mark_type;

   typedef enum logic [2:0] {
      ENC_ASCII     = 3'd0,
      ENC_UTF8      = 3'd1,
      ENC_UTF8_MARK = 3'd2,
      ENC_UTF16_LE  = 3'd3,
      ENC_UTF16_BE  = 3'd4,
      ENC_LATIN1    = 3'd5,
      ENC_UNKNOWN   = 3'd6
   } encoding_type;

   typedef enum logic [1:0] {
      EOL_LF    = 2'd0,
      EOL_CRLF  = 2'd1,
      EOL_CR    = 2'd2,
      EOL_MIXED = 2'd3
   } line_ending_type;

   localparam int END_CRLF_BIT = 0;
   localparam int END_LF_BIT   = 1;
   localparam int END_CR_BIT   = 2;

   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;

   // one input word as held in the input stage
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } item_type;

   typedef struct packed {
      logic [2:0] encoding;
      logic [1:0] line_ending;
      logic       has_mark;
      logic [1:0] mark_size;
      logic       has_zero_bytes;
   } result_type;

   typedef struct packed {
      logic       pending_cr;
      logic [1:0] skip_rem;
      logic       skip_chk;
      logic       utf8_ok;
      logic       high_seen;
      logic       zero_seen;
      logic [2:0] ending;
   } scan_state_type;

   typedef struct packed {
      mark_type       mark;
      scan_state_type st;
   } settle_type;

   localparam scan_state_type SCAN_RESET = '{
      pending_cr: 1'b0, skip_rem: 2'd0, skip_chk: 1'b1, utf8_ok: 1'b1,
      high_seen: 1'b0, zero_seen: 1'b0, ending: 3'd0};

   function automatic scan_state_type scan_step(scan_state_type s, logic [7:0] b);
      scan_state_type r;
      logic           done;
      r    = s;
      done = 1'b0;
      if (s.skip_rem != 2'd0) begin
         // continuation bytes are swallowed whatever they hold; a bad one clears utf8_ok
         if (s.skip_chk && (b[7:6] != 2'b10)) begin
            r.utf8_ok  = 1'b0;
            r.skip_chk = 1'b0;
         end
         r.skip_rem = s.skip_rem - 2'd1;
      end else begin
         if (s.pending_cr) begin
            r.pending_cr = 1'b0;
            if (b == CHAR_LF) begin
               r.ending[END_CRLF_BIT] = 1'b1;
               done = 1'b1;
            end else begin
               r.ending[END_CR_BIT] = 1'b1;
            end
         end
         if (!done) begin
            if (b == 8'h00) begin
               r.zero_seen = 1'b1;
            end else if (b == CHAR_CR) begin
               r.pending_cr = 1'b1;
            end else if (b == CHAR_LF) begin
               r.ending[END_LF_BIT] = 1'b1;
            end else if (b[7]) begin
               r.high_seen = 1'b1;
               if ((b & 8'hE0) == 8'hC0) begin
                  r.skip_rem = 2'd1;
               end else if ((b & 8'hF0) == 8'hE0) begin
                  r.skip_rem = 2'd2;
               end else if ((b & 8'hF8) == 8'hF0) begin
                  r.skip_rem = 2'd3;
               end else begin
                  r.utf8_ok = 1'b0;
               end
               r.skip_chk = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // judge the mark from n held bytes, then scan those past it
   function automatic settle_type settle_head(logic [7:0] h0, logic [7:0] h1,
                                              logic [7:0] h2, logic [1:0] n,
                                              scan_state_type s);
      settle_type r;
      r.mark = MARK_NONE;
      r.st   = s;
      if (n == 2'd3 && h0 == 8'hEF && h1 == 8'hBB && h2 == 8'hBF) begin
         r.mark = MARK_UTF8;
      end else if (n >= 2'd2 && h0 == 8'hFF && h1 == 8'hFE) begin
         r.mark = MARK_LE;
      end else if (n >= 2'd2 && h0 == 8'hFE && h1 == 8'hFF) begin
         r.mark = MARK_BE;
      end
      if (r.mark == MARK_NONE && n >= 2'd1) begin
         r.st = scan_step(r.st, h0);
      end
      if (r.mark == MARK_NONE && n >= 2'd2) begin
         r.st = scan_step(r.st, h1);
      end
      if (r.mark != MARK_UTF8 && n == 2'd3) begin
         r.st = scan_step(r.st, h2);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: sv/text_encoding_sniffer_top.sv
// A final word's verdict is registered into the result register when the core takes it.
// Throughput: one word per cycle; the input register holds one word, the result register
// one verdict, and every byte's flag and counter update is computed combinationally.
// A final word stalls only while a previous verdict is still waiting on rsp.
// Reset (synchronous, active high) clears both stages and the scan state; no sweep.
`default_nettype none
module text_encoding_sniffer_top #(
   parameter int SCAN_LIMIT     = 8192,
   parameter int PATTERN_WINDOW = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic [0:0]  req_tuser,   // [0] byte_valid
   input  wire logic        req_tlast,   // last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [2:0] encoding, [4:3] line_ending,
                                         // [5] has_mark, [7:6] mark_size,
                                         // [8] has_zero_bytes, [15:9] zero
);
   import tes_pkg::*;

   logic       take, item_valid;
   item_type   item;
   result_type result;

   tes_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   tes_core #(
      .SCAN_LIMIT     (SCAN_LIMIT),
      .PATTERN_WINDOW (PATTERN_WINDOW)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tdata = {7'd0, result.has_zero_bytes, result.mark_size, result.has_mark,
                       result.line_ending, result.encoding};

endmodule
`default_nettype wire

FILE: sv/tes_in_stage.sv
`default_nettype none
module tes_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [7:0]        req_tdata,   // data_byte
   input  wire logic [0:0]        req_tuser,   // byte_valid
   input  wire logic              req_tlast,
   input  wire logic              take,
   output logic                   item_valid,
   output tes_pkg::item_type      item
);
   import tes_pkg::*;

   logic     vld_ff, vld_in;
   item_type item_ff;

   assign req_tready = !vld_ff || take;

   always_comb begin
      vld_in = vld_ff;
      if (req_tvalid && req_tready) begin
         vld_in = 1'b1;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.data_byte  <= req_tdata;
         item_ff.byte_valid <= req_tuser[0];
         item_ff.last       <= req_tlast;
      end
   end

   assign item_valid = vld_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

FILE: sv/tes_core.sv
`default_nettype none
module tes_core #(
   parameter int SCAN_LIMIT     = 8192,
   parameter int PATTERN_WINDOW = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_valid,
   input  wire tes_pkg::item_type item,
   output logic                   take,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   output tes_pkg::result_type    rsp_result
);
   import tes_pkg::*;

   localparam int POS_W = $clog2(SCAN_LIMIT + 1);

   logic [POS_W-1:0] pos_ff, pos_in, pos_upd;
   logic [7:0]       h0_ff, h0_in, h1_ff, h1_in;
   mark_type         mark_ff, mark_in, mark_fin;
   scan_state_type   st_ff, st_in, st_upd, st_fin;
   logic             odd_ff, odd_in, odd_upd;
   logic             rsp_tvalid_ff, rsp_tvalid_in;
   result_type       result_ff, result_in;
   logic             in_scan, out_free;
   settle_type       head_set, fin_set;

   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign take     = item_valid && (!item.last || out_free);
   assign in_scan  = item.byte_valid && (32'(pos_ff) < SCAN_LIMIT);

   assign head_set = settle_head(h0_ff, h1_ff, item.data_byte, 2'd3, st_ff);

   always_comb begin
      pos_upd = pos_ff;
      h0_in   = h0_ff;
      h1_in   = h1_ff;
      mark_in = mark_ff;
      st_upd  = st_ff;
      odd_upd = odd_ff;
      if (in_scan) begin
         if (pos_ff[0] && (32'(pos_ff) < PATTERN_WINDOW) && item.data_byte != 8'h00) begin
            odd_upd = 1'b0;
         end
         if (pos_ff == POS_W'(0)) begin
            h0_in = item.data_byte;
         end else if (pos_ff == POS_W'(1)) begin
            h1_in = item.data_byte;
         end else if (pos_ff == POS_W'(2)) begin
            mark_in = head_set.mark;
            st_upd  = head_set.st;
         end else begin
            st_upd = scan_step(st_ff, item.data_byte);
         end
         pos_upd = pos_ff + POS_W'(1);
      end
   end

   // a short file never reached the mark decision: settle what is held
   assign fin_set = settle_head(h0_in, h1_in, item.data_byte, pos_upd[1:0], st_upd);

   always_comb begin
      mark_fin = mark_in;
      st_fin   = st_upd;
      if (pos_upd < POS_W'(3)) begin
         mark_fin = fin_set.mark;
         st_fin   = fin_set.st;
      end
      if (st_fin.pending_cr) begin
         st_fin.ending[END_CR_BIT] = 1'b1;
      end
      if (st_fin.skip_rem != 2'd0) begin
         st_fin.utf8_ok = 1'b0;
      end
   end

   always_comb begin
      result_in.has_mark       = (mark_fin != MARK_NONE);
      result_in.has_zero_bytes = st_fin.zero_seen;
      case (mark_fin)
         MARK_UTF8: result_in.mark_size = 2'd3;
         MARK_LE:   result_in.mark_size = 2'd2;
         MARK_BE:   result_in.mark_size = 2'd2;
         default:   result_in.mark_size = 2'd0;
      endcase
      if (mark_fin == MARK_UTF8) begin
         result_in.encoding = ENC_UTF8_MARK;
      end else if (mark_fin == MARK_LE) begin
         result_in.encoding = ENC_UTF16_LE;
      end else if (mark_fin == MARK_BE) begin
         result_in.encoding = ENC_UTF16_BE;
      end else if (st_fin.zero_seen) begin
         result_in.encoding = (odd_upd && pos_upd >= POS_W'(4)) ? ENC_UTF16_LE : ENC_UNKNOWN;
      end else if (!st_fin.high_seen) begin
         result_in.encoding = ENC_ASCII;
      end else if (st_fin.utf8_ok) begin
         result_in.encoding = ENC_UTF8;
      end else begin
         result_in.encoding = ENC_LATIN1;
      end
      case (st_fin.ending)
         3'b000, 3'b010: result_in.line_ending = EOL_LF;
         3'b001:         result_in.line_ending = EOL_CRLF;
         3'b100:         result_in.line_ending = EOL_CR;
         default:        result_in.line_ending = EOL_MIXED;
      endcase
   end

   always_comb begin
      pos_in        = pos_ff;
      st_in         = st_ff;
      odd_in        = odd_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (take) begin
         if (item.last) begin
            // verdict given: back to a clean slate for the next file
            pos_in        = '0;
            st_in         = SCAN_RESET;
            odd_in        = 1'b1;
            rsp_tvalid_in = 1'b1;
         end else begin
            pos_in = pos_upd;
            st_in  = st_upd;
            odd_in = odd_upd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         mark_ff       <= MARK_NONE;
         st_ff         <= SCAN_RESET;
         odd_ff        <= 1'b1;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         st_ff         <= st_in;
         odd_ff        <= odd_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         if (take) begin
            mark_ff <= item.last ? MARK_NONE : mark_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         h0_ff <= h0_in;
         h1_ff <= h1_in;
      end
      if (take && item.last) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_result = result_ff;

`ifndef ASSERT_OFF
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid_ff && !(take && item.last) |=> !rsp_tvalid_ff)
      else $error("result raised without a final word");
   a_clear_after_verdict: assert property (@(posedge clock) disable iff (reset)
      take && item.last |=> pos_ff == '0 && mark_ff == MARK_NONE)
      else $error("state not cleared after verdict");
   a_pos_saturates: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= SCAN_LIMIT)
      else $error("byte position past scan limit");
   a_mark_after_head: assert property (@(posedge clock) disable iff (reset)
      mark_ff != MARK_NONE |-> pos_ff >= POS_W'(3))
      else $error("mark set before three bytes held");
`endif

endmodule
`default_nettype wire
